// File: sv/pwtmix_pkg.sv
// Shared types and constants of the polyphonic wavetable mixer.
package pwtmix_pkg;

  localparam int KEY_W       = 7;
  localparam int VEL_W       = 7;
  localparam int WAVE_AW     = 10;
  localparam int TABLE_SIZE  = 1 << WAVE_AW;
  localparam int WAVE_W      = 16;
  localparam int STEP_W      = 26;
  localparam int FRAC_W      = 16;
  // Phase is 10.16 over the wavetable: index bits above the fraction.
  localparam int PHASE_W     = WAVE_AW + FRAC_W;
  localparam int KEY_COUNT   = 1 << KEY_W;
  localparam int DAC_W       = 12;
  localparam int PROD_W      = WAVE_W + VEL_W + 1;
  localparam int TERM_SHIFT  = 4;
  localparam int MIX_SHIFT   = 10;
  localparam int DAC_OFFSET  = 2048;
  localparam int DAC_MAX     = 4095;

  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_NOTE_ON   = 3'd1,
    KIND_NOTE_OFF  = 3'd2,
    KIND_LOAD_WAVE = 3'd3,
    KIND_LOAD_STEP = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_NOTE_ON,
    OP_NOTE_OFF
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_WALK,
    ST_FLUSH,
    ST_DRAIN
  } seq_state_e;

  typedef struct packed {
    logic [2:0]               kind;
    logic [KEY_W-1:0]         key;
    logic [VEL_W-1:0]         velocity;
    logic [WAVE_AW-1:0]       wave_index;
    logic signed [WAVE_W-1:0] wave_value;
    logic [STEP_W-1:0]        step_value;
  } item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   note;
    logic [STEP_W-1:0]  step;
    logic [PHASE_W-1:0] phase;
    logic [VEL_W-1:0]   volume;
  } voice_t;

  // Per-voice token from the sequencer to the mixing datapath.
  typedef struct packed {
    logic               clr;
    logic               tok;
    logic               act;
    logic               last;
    logic [WAVE_AW-1:0] addr;
    logic [VEL_W-1:0]   vol;
  } mix_ctl_t;

  typedef struct packed {
    logic                     en;
    logic [WAVE_AW-1:0]       addr;
    logic signed [WAVE_W-1:0] data;
  } wave_wr_t;

endpackage

// File: sv/polyphonic_wavetable_mixer_top.sv
// Top level of the polyphonic wavetable mixer: stream ports, output register, submodules.
// Loads leave the sequencer idle; note-on/off are bound by the walk over the voice RAM.
// A tick waits for a free output slot, then walks one voice per cycle through
// the shared wavetable read port and multiplier, then the product and accumulator registers and scaling.
// The input is accepted again once the sample sits in the output register.
// Reset clears all voices to inactive and empties the output register; both tables
// hold undefined data until loaded.
module polyphonic_wavetable_mixer_top
  import pwtmix_pkg::*;
#(
  parameter int VOICES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key[6:0], velocity[13:7], wave_index[23:14], wave_value[39:24], step_value[65:40]
  input  logic [71:0] s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // dac_sample[11:0]
  output logic [15:0] m_axis_tdata
);

  localparam int KEY_LO  = 0;
  localparam int VEL_LO  = KEY_LO + KEY_W;
  localparam int WIDX_LO = VEL_LO + VEL_W;
  localparam int WVAL_LO = WIDX_LO + WAVE_AW;
  localparam int STEP_LO = WVAL_LO + WAVE_W;

  item_t    item;
  wave_wr_t wave_wr;
  mix_ctl_t mix_ctl;
  logic     in_ready;
  logic     mix_done;
  logic     out_free;
  logic [DAC_W-1:0] dac;

  logic             out_vld_q;
  logic [DAC_W-1:0] out_data_q;

  // Unpack the slave-side transaction.
  always_comb begin
    item.kind       = s_axis_tuser;
    item.key        = s_axis_tdata[KEY_LO  +: KEY_W];
    item.velocity   = s_axis_tdata[VEL_LO  +: VEL_W];
    item.wave_index = s_axis_tdata[WIDX_LO +: WAVE_AW];
    item.wave_value = s_axis_tdata[WVAL_LO +: WAVE_W];
    item.step_value = s_axis_tdata[STEP_LO +: STEP_W];
  end

  assign s_axis_tready = in_ready;

  // Wavetable writes land in the cycle of the transaction.
  always_comb begin
    wave_wr.en   = s_axis_tvalid && in_ready && (item.kind == KIND_LOAD_WAVE);
    wave_wr.addr = item.wave_index;
    wave_wr.data = item.wave_value;
  end

  // The slot is free if empty or being drained this cycle.
  assign out_free = !out_vld_q || m_axis_tready;

  pwtmix_seq #(
    .VOICES(VOICES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (in_ready),
    .item_i     (item),
    .out_free_i (out_free),
    .mix_done_i (mix_done),
    .mix_ctl_o  (mix_ctl)
  );

  pwtmix_mix #(
    .VOICES(VOICES)
  ) u_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wave_wr_i (wave_wr),
    .ctl_i     (mix_ctl),
    .done_o    (mix_done),
    .dac_o     (dac)
  );

  // Output register: capture the mixed sample, drop it once the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (mix_done) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mix_done) begin
      out_data_q <= dac;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(16 - DAC_W){1'b0}}, out_data_q};

endmodule

// File: sv/pwtmix_seq.sv
// Voice sequencer: walks the voice bank for ticks, note-on and note-off.
module pwtmix_seq
  import pwtmix_pkg::*;
#(
  parameter int VOICES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  item_t    item_i,
  input  logic     out_free_i,
  input  logic     mix_done_i,
  output mix_ctl_t mix_ctl_o
);

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

  seq_state_e state_q, state_d;
  op_e        op_q, op_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic found_q, found_d;
  logic [VOICES-1:0] active_q, active_d;

  logic [KEY_W-1:0] key_q;
  logic [VEL_W-1:0] vel_q;

  logic             s1_vld_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             s1_last_q;

  voice_t vmem [VOICES];
  voice_t vrd_q;
  voice_t vwr_data;
  logic   vwr_en;

  logic [STEP_W-1:0] step_mem [KEY_COUNT];
  logic [STEP_W-1:0] step_rd_q;
  logic [KEY_W-1:0]  step_raddr;
  logic              step_we;

  logic accept;
  logic issue;
  logic clr;
  logic act;
  logic [PHASE_W-1:0] ph;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign step_we    = accept && (item_i.kind == KIND_LOAD_STEP);
  assign step_raddr = in_ready_o ? item_i.key : key_q;

  assign act = active_q[s1_idx_q];
  assign ph  = vrd_q.phase + vrd_q.step;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    idx_d   = idx_q;
    issue   = 1'b0;
    clr     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          case (item_i.kind)
            KIND_TICK: begin
              op_d    = OP_TICK;
              state_d = ST_WAIT;
            end
            KIND_NOTE_ON: begin
              op_d    = (item_i.velocity == '0) ? OP_NOTE_OFF : OP_NOTE_ON;
              state_d = ST_WALK;
            end
            KIND_NOTE_OFF: begin
              op_d    = OP_NOTE_OFF;
              state_d = ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WAIT: begin
        // hold until the output slot can take the mixed sample
        if (out_free_i) begin
          clr     = 1'b1;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        issue = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = (op_q == OP_TICK) ? ST_DRAIN : ST_FLUSH;
        end
      end
      ST_FLUSH: state_d = ST_IDLE;
      ST_DRAIN: begin
        if (mix_done_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    vwr_en   = 1'b0;
    vwr_data = vrd_q;
    active_d = active_q;
    found_d  = accept ? 1'b0 : found_q;
    if (s1_vld_q) begin
      unique case (op_q)
        OP_TICK: begin
          if (act) begin
            vwr_en         = 1'b1;
            vwr_data.phase = ph;
          end
        end
        OP_NOTE_ON: begin
          // take the lowest free voice
          if (!act && !found_q) begin
            vwr_en          = 1'b1;
            vwr_data.note   = key_q;
            vwr_data.step   = step_rd_q;
            vwr_data.phase  = '0;
            vwr_data.volume = vel_q;
            active_d[s1_idx_q] = 1'b1;
            found_d         = 1'b1;
          end
        end
        OP_NOTE_OFF: begin
          if (act && (vrd_q.note == key_q) && !found_q) begin
            active_d[s1_idx_q] = 1'b0;
            found_d            = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mix_ctl_o.clr  = clr;
    mix_ctl_o.tok  = s1_vld_q && (op_q == OP_TICK);
    mix_ctl_o.act  = act;
    mix_ctl_o.last = s1_last_q;
    mix_ctl_o.addr = ph[PHASE_W-1 -: WAVE_AW];
    mix_ctl_o.vol  = vrd_q.volume;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_TICK;
      idx_q    <= '0;
      found_q  <= 1'b0;
      active_q <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      idx_q    <= idx_d;
      found_q  <= found_d;
      active_q <= active_d;
      s1_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= idx_q;
    s1_last_q <= (idx_q == LAST_IDX);
    if (accept) begin
      key_q <= item_i.key;
      vel_q <= item_i.velocity;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwr_en) begin
      vmem[s1_idx_q] <= vwr_data;
    end
    vrd_q <= vmem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (step_we) begin
      step_mem[item_i.key] <= item_i.step_value;
    end
    step_rd_q <= step_mem[step_raddr];
  end

endmodule

// File: sv/pwtmix_mix.sv
// Mixing datapath: wavetable read, shared multiplier, accumulator and output scaling.
module pwtmix_mix
  import pwtmix_pkg::*;
#(
  parameter int VOICES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wave_wr_t         wave_wr_i,
  input  mix_ctl_t         ctl_i,
  output logic             done_o,
  output logic [DAC_W-1:0] dac_o
);

  localparam int TERM_W = PROD_W - TERM_SHIFT;
  localparam int ACC_W  = TERM_W + $clog2(VOICES) + 1;
  localparam int MIX_W  = ACC_W - MIX_SHIFT;
  localparam int BIAS_W = MIX_W + 2;

  logic signed [WAVE_W-1:0] wave_mem [TABLE_SIZE];
  logic signed [WAVE_W-1:0] wave_rd_q;

  logic             a_tok_q, a_act_q, a_last_q;
  logic [VEL_W-1:0] a_vol_q;

  logic signed [PROD_W-1:0] prod_q;
  logic                     b_tok_q, b_act_q, b_last_q;

  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     c_last_q;

  logic signed [MIX_W-1:0]  mixed;
  logic signed [BIAS_W-1:0] biased;

  always_ff @(posedge clk_i) begin
    if (wave_wr_i.en) begin
      wave_mem[wave_wr_i.addr] <= wave_wr_i.data;
    end
    wave_rd_q <= wave_mem[ctl_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tok_q  <= 1'b0;
      b_tok_q  <= 1'b0;
      c_last_q <= 1'b0;
    end else begin
      a_tok_q  <= ctl_i.tok;
      b_tok_q  <= a_tok_q;
      c_last_q <= b_tok_q && b_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_act_q  <= ctl_i.act;
    a_last_q <= ctl_i.last;
    a_vol_q  <= ctl_i.vol;
    prod_q   <= wave_rd_q * $signed({1'b0, a_vol_q});
    b_act_q  <= a_act_q;
    b_last_q <= a_last_q;
  end

  // floor shift: dropping low bits of a two's complement value
  assign term = prod_q[PROD_W-1:TERM_SHIFT];

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (b_tok_q && b_act_q) begin
      acc_q <= acc_q + ACC_W'(term);
    end
  end

  assign mixed  = acc_q[ACC_W-1:MIX_SHIFT];
  assign biased = BIAS_W'(mixed) + BIAS_W'(DAC_OFFSET);
  assign done_o = c_last_q;

  always_comb begin
    if (biased[BIAS_W-1]) begin
      dac_o = '0;
    end else if (biased > BIAS_W'(DAC_MAX)) begin
      dac_o = DAC_W'(DAC_MAX);
    end else begin
      dac_o = biased[DAC_W-1:0];
    end
  end

endmodule

// File: tb/tb.sv
// Self-checking stream testbench for the polyphonic wavetable mixer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwtmix_pkg::*;

  localparam int         VOICES         = 16;
  localparam int         RANDOM_ITEMS   = 700;
  localparam int         WATCHDOG_LIMIT = 2000;
  // Leave room for stray transactions after the last one.
  localparam int         SETTLE_CYCLES  = 2 * (VOICES + 6);
  localparam logic [2:0] KIND_SPARE_LO  = 3'd5;  // kinds 5..7 carry no meaning
  localparam logic [2:0] KIND_SPARE_HI  = 3'd7;
  localparam longint     PHASE_PERIOD   = longint'(TABLE_SIZE) << FRAC_W;
  // Only every WAVE_STRIDE-th wavetable entry is preloaded.
  localparam int         WAVE_STRIDE    = 8;
  localparam int         STEP_ALIGN     = FRAC_W + $clog2(WAVE_STRIDE);

  // Voice bank shadow plus the queue of DAC samples still owed by the block.
  class voice_mixer_sb;
    logic                     active [VOICES];
    logic [KEY_W-1:0]         note   [VOICES];
    logic [STEP_W-1:0]        step   [VOICES];
    logic [PHASE_W-1:0]       phase  [VOICES];
    logic [VEL_W-1:0]         volume [VOICES];
    logic signed [WAVE_W-1:0] wave_mem [TABLE_SIZE];
    logic [STEP_W-1:0]        step_mem [KEY_COUNT];
    logic [DAC_W-1:0]         expected_dac [$];
    int                       errors;

    function new();
      for (int v = 0; v < VOICES; v++) begin
        active[v] = 1'b0;
        note[v]   = '0;
        step[v]   = '0;
        phase[v]  = '0;
        volume[v] = '0;
      end
      foreach (wave_mem[i]) wave_mem[i] = '0;
      foreach (step_mem[i]) step_mem[i] = '0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function int pending();
      return expected_dac.size();
    endfunction

    function int free_voices();
      int n;
      n = 0;
      for (int v = 0; v < VOICES; v++) if (!active[v]) n++;
      return n;
    endfunction

    function bit note_playing(logic [KEY_W-1:0] k);
      for (int v = 0; v < VOICES; v++) if (active[v] && note[v] == k) return 1'b1;
      return 1'b0;
    endfunction

    // Pick the note of a random active voice, if any.
    function bit pick_active_note(output logic [KEY_W-1:0] k);
      int busy [$];
      k = '0;
      for (int v = 0; v < VOICES; v++) if (active[v]) busy.push_back(v);
      if (busy.size() == 0) return 1'b0;
      k = note[busy[$urandom_range(busy.size() - 1)]];
      return 1'b1;
    endfunction

    // Free the lowest active voice on this note.
    function void release_note(logic [KEY_W-1:0] k);
      for (int v = 0; v < VOICES; v++) begin
        if (active[v] && note[v] == k) begin
          active[v] = 1'b0;
          return;
        end
      end
    endfunction

    // Claim the lowest free voice; a full bank drops the note.
    function void claim_voice(logic [KEY_W-1:0] k, logic [VEL_W-1:0] vel);
      for (int v = 0; v < VOICES; v++) begin
        if (!active[v]) begin
          note[v]   = k;
          step[v]   = step_mem[k];
          phase[v]  = '0;
          volume[v] = vel;
          active[v] = 1'b1;
          return;
        end
      end
    endfunction

    // Advance every active phase, then mix, scale, offset and clamp.
    function logic [DAC_W-1:0] mix_sample();
      longint acc;
      longint ph;
      longint prod;
      acc = 0;
      for (int v = 0; v < VOICES; v++) begin
        if (active[v]) begin
          ph = longint'(phase[v]) + longint'(step[v]);
          if (ph >= PHASE_PERIOD) ph -= PHASE_PERIOD;
          phase[v] = ph[PHASE_W-1:0];
          prod = longint'(wave_mem[ph[PHASE_W-1:FRAC_W]]) * longint'(volume[v]);
          acc += prod >>> TERM_SHIFT;
        end
      end
      acc = (acc >>> MIX_SHIFT) + DAC_OFFSET;
      if (acc > DAC_MAX) acc = DAC_MAX;
      else if (acc < 0) acc = 0;
      return acc[DAC_W-1:0];
    endfunction

    function void accept_item(item_t it);
      case (it.kind)
        KIND_TICK: begin
          expected_dac.push_back(mix_sample());
        end
        KIND_NOTE_ON: begin
          if (it.velocity == 0) release_note(it.key);
          else claim_voice(it.key, it.velocity);
        end
        KIND_NOTE_OFF:  release_note(it.key);
        KIND_LOAD_WAVE: wave_mem[it.wave_index] = it.wave_value;
        KIND_LOAD_STEP: step_mem[it.key] = it.step_value;
        default: ;
      endcase
    endfunction

    task check_dac(logic [DAC_W-1:0] got);
      logic [DAC_W-1:0] want;
      if (expected_dac.size() == 0) begin
        report($sformatf("dac_sample %0d arrived with no tick outstanding", got));
      end else begin
        want = expected_dac.pop_front();
        if (got !== want) report($sformatf("dac_sample got %0d, want %0d", got, want));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  voice_mixer_sb mixer_sb = new();
  int send_idle_pct  = 36;
  int recv_idle_pct  = 74;
  int stalled_cycles = 0;

  polyphonic_wavetable_mixer_top #(
    .VOICES(VOICES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: redraw ready on every falling edge.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check results and watch for a hung handshake.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) mixer_sb.check_dac(m_axis_tdata[DAC_W-1:0]);
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic item_t make_item(logic [2:0] kind, logic [KEY_W-1:0] key,
                                      logic [VEL_W-1:0] vel, logic [WAVE_AW-1:0] widx,
                                      logic signed [WAVE_W-1:0] wval,
                                      logic [STEP_W-1:0] sval);
    item_t it;
    it.kind       = kind;
    it.key        = key;
    it.velocity   = vel;
    it.wave_index = widx;
    it.wave_value = wval;
    it.step_value = sval;
    return it;
  endfunction

  // Mostly slow phase steps so voices sweep the table; now and then any step at all.
  // Steps stay on whole multiples of the preload stride, so ticks only read loaded entries.
  function automatic logic [STEP_W-1:0] random_step();
    logic [STEP_W-1:0] s;
    if ($urandom_range(7) == 0) s = STEP_W'($urandom);
    else s = STEP_W'($urandom_range(0, 4) << STEP_ALIGN);
    s[STEP_ALIGN-1:0] = '0;
    return s;
  endfunction

  function automatic item_t random_item();
    return make_item(3'($urandom), KEY_W'($urandom), VEL_W'($urandom),
                     WAVE_AW'($urandom), WAVE_W'($urandom), STEP_W'($urandom));
  endfunction

  // Present one transaction after a random gap; return on the falling edge after acceptance.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {6'd0, it.step_value, it.wave_value, it.wave_index, it.velocity, it.key};
    do @(posedge clk_i); while (!s_axis_tready);
    mixer_sb.accept_item(it);
    @(negedge clk_i);
  endtask

  // Hold the input and wait for every owed sample.
  task automatic drain_samples();
    s_axis_tvalid <= 1'b0;
    while (mixer_sb.pending() != 0) @(negedge clk_i);
  endtask

  // Fill the strided wavetable entries and every step entry before any note plays.
  task automatic preload_tables();
    for (int i = 0; i < TABLE_SIZE; i += WAVE_STRIDE) begin
      send_item(make_item(KIND_LOAD_WAVE, KEY_W'($urandom), VEL_W'($urandom),
                          WAVE_AW'(i), WAVE_W'($urandom), STEP_W'($urandom)));
    end
    for (int k = 0; k < KEY_COUNT; k++) begin
      send_item(make_item(KIND_LOAD_STEP, KEY_W'(k), VEL_W'($urandom), WAVE_AW'($urandom),
                          WAVE_W'($urandom), random_step()));
    end
  endtask

  task automatic play_directed();
    // Park every voice on entry 0 with a zero step and full volume.
    send_item(make_item(KIND_LOAD_WAVE, 0, 0, 0, 16'sh7fff, 0));
    send_item(make_item(KIND_LOAD_STEP, 0, 0, 0, 0, 0));
    for (int v = 0; v < VOICES; v++) send_item(make_item(KIND_NOTE_ON, 0, 127, 0, 0, 0));
    // Bank is full: drop this one.
    send_item(make_item(KIND_NOTE_ON, 1, 127, 0, 0, 0));
    // Full positive swing clamps high, full negative swing clamps low.
    send_item(make_item(KIND_TICK, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_LOAD_WAVE, 0, 0, 0, 16'sh8000, 0));
    send_item(make_item(KIND_TICK, 0, 0, 0, 0, 0));
    // Release with no matching note, then velocity zero as release, then a plain release.
    send_item(make_item(KIND_NOTE_OFF, 99, 0, 0, 0, 0));
    send_item(make_item(KIND_NOTE_ON, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_NOTE_OFF, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_SPARE_HI, 127, 127, 1023, 16'sh7fff, '1));
    // Largest step on the top key, picked up by the freed lowest voice.
    send_item(make_item(KIND_LOAD_STEP, 127, 0, 1023, 0, '1));
    send_item(make_item(KIND_NOTE_ON, 127, 1, 0, 0, 0));
    send_item(make_item(KIND_LOAD_WAVE, 0, 0, 1023, 16'sh1234, 0));
    send_item(make_item(KIND_TICK, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_TICK, 0, 0, 0, 0, 0));
  endtask

  // Random traffic; only transactions that change state or give a sample count.
  task automatic play_random(input int count);
    int               done;
    int               roll;
    bit               counts;
    item_t            it;
    logic [KEY_W-1:0] held;
    done = 0;
    while (done < count) begin
      it     = random_item();
      roll   = $urandom_range(99);
      counts = 1'b1;
      if (roll < 30) begin
        it.kind = KIND_TICK;
      end else if (roll < 55) begin
        it.kind = KIND_NOTE_ON;
        if (it.velocity == 0) it.velocity = 1;
        counts = (mixer_sb.free_voices() != 0);
      end else if (roll < 60) begin
        it.kind     = KIND_NOTE_ON;
        it.velocity = '0;
        if (mixer_sb.pick_active_note(held)) it.key = held;
        counts = mixer_sb.note_playing(it.key);
      end else if (roll < 83) begin
        it.kind = KIND_NOTE_OFF;
        if ($urandom_range(9) != 0 && mixer_sb.pick_active_note(held)) it.key = held;
        counts = mixer_sb.note_playing(it.key);
      end else if (roll < 91) begin
        it.kind = KIND_LOAD_WAVE;
      end else if (roll < 98) begin
        it.kind       = KIND_LOAD_STEP;
        it.step_value = random_step();
      end else begin
        it.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        counts  = 1'b0;
      end
      send_item(it);
      if (counts) done++;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_TICK;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    preload_tables();
    play_directed();
    play_random(RANDOM_ITEMS / 3);
    drain_samples();

    send_idle_pct = 74;
    recv_idle_pct = 36;
    play_random(RANDOM_ITEMS / 3);
    drain_samples();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    play_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    drain_samples();

    // Allow any stray transaction to show up before judging.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mixer_sb.pending() != 0) begin
      mixer_sb.report($sformatf("%0d samples never arrived", mixer_sb.pending()));
    end
    if (mixer_sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/pwtmix_pkg.sv
sv/pwtmix_seq.sv
sv/pwtmix_mix.sv
sv/polyphonic_wavetable_mixer_top.sv
tb/tb.sv
